@@ rtl/core/tisp_pkg.sv @@
// ----------------------------------------------------------------------------
// tisp_pkg
// Shared types and constants for the prefix tree block.
// ----------------------------------------------------------------------------
package tisp_pkg;

    localparam int MAX_NODES_DEF = 1024;
    localparam int ALPHABET_DEF  = 26;

    localparam int OP_W     = 2;
    localparam int LETTER_W = 5;
    localparam int LCMP_W   = 9;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
    localparam logic [OP_W-1:0] OP_PREFIX = 2'd2;
    localparam logic [OP_W-1:0] OP_SPARE  = 2'd3;

    typedef struct packed {
        logic clr;
        logic acc;
        logic look;
        logic fin;
        logic load;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic walk;
        logic last;
        logic out_free;
    } dp_sts_t;

endpackage

@@ rtl/core/tisp_ctrl.sv @@
// ----------------------------------------------------------------------------
// tisp_ctrl
// Sequencer: clearing pass, item accept, child lookup, word-end access, result.
// ----------------------------------------------------------------------------
module tisp_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              s_tlast,
    input  tisp_pkg::dp_sts_t sts,
    output tisp_pkg::dp_cmd_t cmd
);
    import tisp_pkg::*;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_LOOK  = 3'd2;
    localparam logic [2:0] ST_FIN   = 3'd3;
    localparam logic [2:0] ST_RES   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       acc;

    assign s_tready = (state_reg == ST_IDLE);
    assign acc      = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr = 1'b1;
                if (sts.clr_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (acc) begin
                    cmd.acc = 1'b1;
                    if (sts.walk) begin
                        state_next = ST_LOOK;
                    end else if (s_tlast) begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_LOOK: begin
                cmd.look   = 1'b1;
                state_next = sts.last ? ST_FIN : ST_IDLE;
            end
            ST_FIN: begin
                cmd.fin    = 1'b1;
                state_next = ST_RES;
            end
            ST_RES: begin
                if (sts.out_free) begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/core/tisp_dp.sv @@
// ----------------------------------------------------------------------------
// tisp_dp
// Datapath: child table and word-end memories, walk state, node allocator,
// result register.
// ----------------------------------------------------------------------------
module tisp_dp #(
    parameter int MAX_NODES = tisp_pkg::MAX_NODES_DEF,
    parameter int ALPHABET  = tisp_pkg::ALPHABET_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  tisp_pkg::dp_cmd_t             cmd,
    output tisp_pkg::dp_sts_t             sts,
    input  logic [tisp_pkg::OP_W-1:0]     in_op,
    input  logic [tisp_pkg::LETTER_W-1:0] in_letter,
    input  logic                          in_has_letter,
    input  logic                          in_last,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic                          out_found,
    output logic                          out_pool_full
);
    import tisp_pkg::*;

    localparam int SLOTS  = MAX_NODES * ALPHABET;
    localparam int NODE_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CNT_W  = $clog2(MAX_NODES + 1);
    localparam int SLOT_W = $clog2(SLOTS);

    logic [NODE_W-1:0] child_mem [SLOTS];
    logic              mark_mem  [MAX_NODES];

    logic [OP_W-1:0]   op_reg;
    logic              last_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [NODE_W-1:0] cursor_reg;
    logic              missing_reg;
    logic              failed_reg;
    logic [CNT_W-1:0]  free_reg;
    logic [SLOT_W-1:0] clr_reg;
    logic [NODE_W-1:0] child_q;
    logic              mark_q;
    logic              out_valid_reg;
    logic              found_reg;
    logic              full_reg;

    logic [OP_W-1:0]   op_norm;
    logic              letter_ok;
    logic              blocked;
    logic [SLOT_W-1:0] slot_calc;
    logic              alloc;
    logic              child_we;
    logic [SLOT_W-1:0] child_wa;
    logic [NODE_W-1:0] child_wd;
    logic              mark_we;
    logic [NODE_W-1:0] mark_a;
    logic              mark_wd;
    logic              ok;
    logic              found_calc;

    assign op_norm   = (in_op == OP_SPARE) ? OP_PREFIX : in_op;
    assign letter_ok = {{(LCMP_W-LETTER_W){1'b0}}, in_letter} < LCMP_W'(ALPHABET);
    assign blocked   = missing_reg || failed_reg;
    assign slot_calc = SLOT_W'(cursor_reg) * SLOT_W'(ALPHABET) + SLOT_W'(in_letter);

    assign alloc = cmd.look && (child_q == '0) && (op_reg == OP_INSERT)
                   && (free_reg < CNT_W'(MAX_NODES));

    assign child_we = cmd.clr || alloc;
    assign child_wa = cmd.clr ? clr_reg : slot_reg;
    assign child_wd = cmd.clr ? '0 : NODE_W'(free_reg);

    assign ok      = !missing_reg && !failed_reg;
    assign mark_we = (cmd.clr && (clr_reg < SLOT_W'(MAX_NODES)))
                     || (cmd.fin && (op_reg == OP_INSERT) && ok);
    assign mark_a  = cmd.clr ? NODE_W'(clr_reg) : cursor_reg;
    assign mark_wd = !cmd.clr;

    always_comb begin
        case (op_reg)
            OP_INSERT: found_calc = ok;
            OP_SEARCH: found_calc = ok && mark_q;
            default:   found_calc = ok;
        endcase
    end

    assign sts.clr_done = (clr_reg == SLOT_W'(SLOTS - 1));
    assign sts.walk     = in_has_letter && !blocked && letter_ok;
    assign sts.last     = last_reg;
    assign sts.out_free = !out_valid_reg || m_tready;

    assign m_tvalid      = out_valid_reg;
    assign out_found     = found_reg;
    assign out_pool_full = full_reg;

    always_ff @(posedge aclk) begin
        if (child_we) begin
            child_mem[child_wa] <= child_wd;
        end
        child_q <= child_mem[slot_calc];
    end

    always_ff @(posedge aclk) begin
        if (mark_we) begin
            mark_mem[mark_a] <= mark_wd;
        end
        mark_q <= mark_mem[mark_a];
    end

    always_ff @(posedge aclk) begin
        if (cmd.acc) begin
            op_reg   <= op_norm;
            last_reg <= in_last;
            slot_reg <= slot_calc;
        end
        if (cmd.load) begin
            found_reg <= found_calc;
            full_reg  <= (op_reg == OP_INSERT) && failed_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_reg    <= '0;
            missing_reg   <= 1'b0;
            failed_reg    <= 1'b0;
            free_reg      <= CNT_W'(1);
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.clr) begin
                clr_reg <= clr_reg + SLOT_W'(1);
            end
            if (cmd.acc && in_has_letter && !blocked && !letter_ok) begin
                missing_reg <= 1'b1;
            end
            if (cmd.look) begin
                if (child_q != '0) begin
                    cursor_reg <= child_q;
                end else if (op_reg != OP_INSERT) begin
                    missing_reg <= 1'b1;
                end else if (!alloc) begin
                    failed_reg <= 1'b1;
                end else begin
                    cursor_reg <= NODE_W'(free_reg);
                    free_reg   <= free_reg + CNT_W'(1);
                end
            end
            if (cmd.load) begin
                cursor_reg  <= '0;
                missing_reg <= 1'b0;
                failed_reg  <= 1'b0;
            end
            if (cmd.load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

@@ rtl/core/trie_insert_search_prefix.sv @@
// ----------------------------------------------------------------------------
// trie_insert_search_prefix
// Prefix tree over a letter alphabet in a fixed node pool: insert, exact
// search and prefix search, one letter per item, one result per word.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                        | tuser                | tlast
//  s_      | in  | [4:0] letter                 | [1:0] op, [2] has_l  | last item
//  m_      | out | [0] found, [1] pool_full     | -                    | -
//
//  A letter item is accepted with a child-table read, then looked up or
//  allocated; the child read must return before the next cursor is known.
//  An item with no letter, a bad letter or a blocked walk is only accepted.
//  The last item of a word adds a word-end access and a result load.
//  After reset a clearing pass over all MAX_NODES*ALPHABET child slots
//  (26624 by default) zeroes both memories; s_tready is low during it.
//  A result waits in the output register; items are taken meanwhile, and
//  only the next word's result waits on m_tready.
module trie_insert_search_prefix #(
    parameter int MAX_NODES = tisp_pkg::MAX_NODES_DEF,
    parameter int ALPHABET  = tisp_pkg::ALPHABET_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [4:0] letter, [7:5] zero
    input  logic [2:0] s_tuser,   // [1:0] op, [2] has_letter
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] found, [1] pool_full, [7:2] zero
);
    import tisp_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;
    logic    found;
    logic    pool_full;

    tisp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tlast  (s_tlast),
        .sts      (sts),
        .cmd      (cmd)
    );

    tisp_dp #(
        .MAX_NODES (MAX_NODES),
        .ALPHABET  (ALPHABET)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .in_op         (s_tuser[1:0]),
        .in_letter     (s_tdata[4:0]),
        .in_has_letter (s_tuser[2]),
        .in_last       (s_tlast),
        .m_tready      (m_tready),
        .m_tvalid      (m_tvalid),
        .out_found     (found),
        .out_pool_full (pool_full)
    );

    assign m_tdata = {6'b0, pool_full, found};

endmodule

@@ verif/trie_insert_search_prefix_test.sv @@
// ----------------------------------------------------------------------------
// trie_insert_search_prefix_test
// Self-checking bench for the prefix tree: a scoreboard keeps its own copy of
// the node pool and predicts the answer of every word. The stimulus runs
// directed corner words, random short words mostly over four letters, then a
// closing phase with no idling on either side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module trie_insert_search_prefix_test;
    import tisp_pkg::*;

    localparam int NODES      = MAX_NODES_DEF;
    localparam int ALPH       = ALPHABET_DEF;
    localparam int RAND_ITEMS = 460;
    localparam int LIMIT      = 500000;

    typedef struct packed {
        logic found;
        logic full;
    } verdict_t;

    typedef struct packed {
        logic [5:0]       len;
        logic [31:0][4:0] l;
    } word_t;

    class trie_scoreboard;
        int unsigned kid_of [NODES*ALPH];
        bit          word_end [NODES];
        int unsigned used;
        int unsigned at;
        bit          lost;
        bit          failed;
        verdict_t    verdicts [$];
        int          errors;
        int          checked;
        int          found_seen;
        int          full_seen;

        function new();
            foreach (kid_of[i]) kid_of[i] = 0;
            foreach (word_end[i]) word_end[i] = 0;
            used = 1;
            at = 0;
            lost = 0;
            failed = 0;
            errors = 0;
            checked = 0;
            found_seen = 0;
            full_seen = 0;
        endfunction

        function int pending();
            return verdicts.size();
        endfunction

        // advance the walk for one accepted item; queue the answer on the last one
        function void note_item(logic [1:0] op_in, logic [4:0] letter, logic has, logic last);
            logic [1:0]  op;
            int unsigned slot;
            int unsigned nxt;
            verdict_t    v;
            op = (op_in == OP_SPARE) ? OP_PREFIX : op_in;
            if (has && !lost && !failed) begin
                if (letter >= ALPH) begin
                    lost = 1;
                end else begin
                    slot = at * ALPH + letter;
                    nxt = kid_of[slot];
                    if (nxt != 0) begin
                        at = nxt;
                    end else if (op != OP_INSERT) begin
                        lost = 1;
                    end else if (used >= NODES) begin
                        failed = 1;
                    end else begin
                        kid_of[slot] = used;
                        at = used;
                        used++;
                    end
                end
            end
            if (last) begin
                v.found = 0;
                v.full = 0;
                if (op == OP_INSERT) begin
                    if (failed) begin
                        v.full = 1;
                    end else if (!lost) begin
                        word_end[at] = 1;
                        v.found = 1;
                    end
                end else if (!lost && !failed) begin
                    v.found = (op == OP_SEARCH) ? word_end[at] : 1'b1;
                end
                verdicts = {verdicts, v};
                at = 0;
                lost = 0;
                failed = 0;
            end
        endfunction

        function void check_result(logic found, logic full);
            verdict_t v;
            if (verdicts.size() == 0) begin
                $display("%0t: unexpected result found=%0b pool_full=%0b", $time, found, full);
                errors++;
                return;
            end
            v = verdicts.pop_front();
            checked++;
            if (found) found_seen++;
            if (full) full_seen++;
            if (found !== v.found) begin
                $display("%0t: found expected %0b actual %0b", $time, v.found, found);
                errors++;
            end
            if (full !== v.full) begin
                $display("%0t: pool_full expected %0b actual %0b", $time, v.full, full);
                errors++;
            end
        endfunction
    endclass

    logic       aclk = 0;
    logic       aresetn = 0;
    logic       s_tvalid = 0;
    logic       s_tready;
    logic [7:0] s_tdata = '0;   // [4:0] letter, [7:5] zero
    logic [2:0] s_tuser = '0;   // [1:0] op, [2] has_letter
    logic       s_tlast = 0;
    logic       m_tvalid;
    logic       m_tready = 0;
    logic [7:0] m_tdata;        // [0] found, [1] pool_full, [7:2] zero

    trie_scoreboard sb;
    word_t          dict [$];
    bit             quiet = 0;
    int             useful = 0;
    int             cycles = 0;

    always #5 aclk = ~aclk;

    trie_insert_search_prefix dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    task automatic send_item(input logic [1:0] op, input logic [4:0] letter,
                             input logic has, input logic last);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 11);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, letter};
        s_tuser  <= {has, op};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        sb.note_item(op, letter, has, last);
        if (has || last) useful++;
    endtask

    task automatic send_word(input word_t w, input logic [1:0] op, input bit mixed);
        int         n;
        logic [1:0] step_op;
        n = w.len;
        if (n == 0) begin
            send_item(op, 5'($urandom_range(0, 31)), 1'b0, 1'b1);
        end else begin
            for (int i = 0; i < n; i++) begin
                // letterless item inside a word: ignored by the walk
                if ($urandom_range(0, 19) == 0)
                    send_item(2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)), 1'b0, 1'b0);
                step_op = (mixed && i < n - 1) ? 2'($urandom_range(0, 3)) : op;
                send_item(step_op, w.l[i], 1'b1, i == n - 1);
            end
        end
        if (op == OP_INSERT && n > 0) begin
            if (dict.size() < 64) dict = {dict, w};
            else dict[$urandom_range(0, 63)] = w;
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat ($urandom_range(1, 6)) @(posedge aclk);
    endtask

    function automatic word_t make_word(int n, int a, int b, int c);
        word_t w;
        w = '0;
        w.len = 6'(n);
        w.l[0] = 5'(a);
        w.l[1] = 5'(b);
        w.l[2] = 5'(c);
        return w;
    endfunction

    function automatic word_t rand_word(int maxlen, int span);
        word_t w;
        w = '0;
        w.len = 6'($urandom_range(0, maxlen));
        for (int i = 0; i < w.len; i++) begin
            if ($urandom_range(0, 39) == 0) w.l[i] = 5'($urandom_range(ALPH, 31));
            else w.l[i] = 5'($urandom_range(0, span - 1));
        end
        return w;
    endfunction

    function automatic word_t any_word();
        word_t w;
        if (dict.size() > 0 && $urandom_range(0, 1) == 1) begin
            w = dict[$urandom_range(0, dict.size() - 1)];
            if ($urandom_range(0, 2) == 0) w.len = 6'($urandom_range(0, w.len));
        end else begin
            w = rand_word(5, ($urandom_range(0, 3) == 0) ? ALPH : 4);
        end
        return w;
    endfunction

    function automatic logic [1:0] pick_op();
        int r;
        r = $urandom_range(0, 19);
        if (r < 7) return OP_INSERT;
        if (r < 14) return OP_SEARCH;
        if (r < 19) return OP_PREFIX;
        return OP_SPARE;
    endfunction

    // result side: check accepted results, stall m_tready in bursts
    initial begin
        int hold;
        hold = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata[0], m_tdata[1]);
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                hold = $urandom_range(0, 10);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        while (cycles < LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("** trie_insert_search_prefix: FAILED **");
        $finish;
    end

    initial begin
        int start;
        int tail;
        sb = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // empty words at the root
        send_word(make_word(0, 0, 0, 0), OP_SEARCH, 0);
        send_word(make_word(0, 0, 0, 0), OP_PREFIX, 0);
        send_word(make_word(0, 0, 0, 0), OP_INSERT, 0);
        send_word(make_word(0, 0, 0, 0), OP_SEARCH, 0);
        // first and last letter, spare op, partial and full matches
        send_word(make_word(2, 0, 25, 0), OP_INSERT, 0);
        send_word(make_word(1, 0, 0, 0), OP_SPARE, 0);
        send_word(make_word(1, 0, 0, 0), OP_SEARCH, 0);
        send_word(make_word(2, 0, 25, 0), OP_SEARCH, 0);
        // letters past the alphabet
        send_word(make_word(1, 31, 0, 0), OP_PREFIX, 0);
        send_word(make_word(2, 0, 26, 0), OP_SEARCH, 0);
        send_word(make_word(3, 0, 26, 1), OP_INSERT, 0);
        // letterless item mid-word, then op switching inside a word
        send_item(OP_INSERT, 5'd17, 1'b0, 1'b0);
        send_item(OP_INSERT, 5'd5, 1'b1, 1'b1);
        send_item(OP_PREFIX, 5'd0, 1'b1, 1'b0);
        send_item(OP_SEARCH, 5'd25, 1'b1, 1'b1);
        send_item(OP_INSERT, 5'd3, 1'b1, 1'b0);
        send_item(OP_SEARCH, 5'd31, 1'b0, 1'b1);
        wait_drained();

        start = useful;
        while (useful - start < RAND_ITEMS)
            send_word(any_word(), pick_op(), $urandom_range(0, 9) == 0);
        wait_drained();

        quiet = 1;
        tail = useful;
        while (useful - tail < 200)
            send_word(any_word(), pick_op(), $urandom_range(0, 9) == 0);
        s_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("%0d letter/end items, %0d words checked: %0d found, %0d pool full",
                 useful, sb.checked, sb.found_seen, sb.full_seen);
        $display("pool use %0d of %0d nodes, %0d mismatches", sb.used, NODES, sb.errors);
        if (sb.errors == 0) begin
            $display("** trie_insert_search_prefix: PASSED **");
        end else begin
            $display("** trie_insert_search_prefix: FAILED **");
        end
        $finish;
    end

endmodule
